// ----- src/rgb_to_ycbcr_mcu_order_writer_unit_defines.svh -----
// Assertion macros for the RGB to YCbCr MCU-order writer.
// Used by rgb_to_ycbcr_mcu_order_writer_unit; needs clk and rst_n in scope.
`ifndef RGB_TO_YCBCR_MCU_ORDER_WRITER_UNIT_DEFINES_SVH
`define RGB_TO_YCBCR_MCU_ORDER_WRITER_UNIT_DEFINES_SVH

// same-cycle implication
`define RYW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RYW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ryw_pkg.sv -----
// Shared constants and helpers for the RGB to YCbCr MCU-order writer.
// No dependencies.
`default_nettype none

package ryw_pkg;

    // Q16 color coefficients
    localparam int Y_R   = 19595;
    localparam int Y_G   = 38470;
    localparam int Y_B   = 7471;
    localparam int CB_R  = -11076;
    localparam int CB_G  = -21692;
    localparam int CB_B  = 32768;
    localparam int CR_R  = 32768;
    localparam int CR_G  = -27460;
    localparam int CR_B  = -5308;
    localparam int C_OFS = 128 << 16;

    localparam int ACC_W    = 26;
    localparam int LIMIT_W  = 9;
    localparam int OFFSET_W = 24;

    typedef enum logic [0:0] {
        REG_WIDTH_IN_MCUS  = 1'b0,
        REG_HEIGHT_IN_MCUS = 1'b1
    } reg_index_t;

    typedef logic signed [ACC_W-1:0] acc_t;

    // floor of a Q16 sum, clamped to 0..255
    function automatic logic [7:0] q16_to_byte(input acc_t acc);
        logic [7:0] res;
        if (acc[ACC_W-1])
            res = 8'd0;
        else if (|acc[ACC_W-2:24])
            res = 8'hFF;
        else
            res = acc[23:16];
        return res;
    endfunction

    // clamp a block count to 1..max_blocks
    function automatic logic [LIMIT_W-1:0] limit_blocks(input logic [7:0] v,
                                                        input logic [LIMIT_W-1:0] max_blocks);
        logic [LIMIT_W-1:0] res;
        if (v == 8'd0)
            res = LIMIT_W'(1);
        else if ({1'b0, v} > max_blocks)
            res = max_blocks;
        else
            res = {1'b0, v};
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/rgb_to_ycbcr_mcu_order_writer_unit.sv -----
// RGB to YCbCr converter with 16x16 MCU-order byte offsets, APB config.
// Depends on ryw_pkg and rgb_to_ycbcr_mcu_order_writer_unit_defines.svh.
//
// channel   | dir | handshake         | payload
// s_*       | in  | s_tvalid/s_tready | s_tdata: red, green, blue
// m_*       | out | m_tvalid/m_tready | m_tdata: Y, Cb, Cr, offset; m_tlast: last pixel
// apb       | in  | psel/penable      | width_in_mcus @0x0, height_in_mcus @0x4
//
// Two register stages: stage 1 holds the pixel with its offset and last flag
// (raster counters step on accept), stage 2 holds the converted result.
// One item per cycle sustained while m_tready stays high; m_tvalid rises once the item moves from stage 1 into stage 2.
// s_tready drops only while both stages hold an item and m_tready is low.
// Reset clears valids and counters; config returns to 128 x 128 MCUs.
`default_nettype none

`include "rgb_to_ycbcr_mcu_order_writer_unit_defines.svh"

module rgb_to_ycbcr_mcu_order_writer_unit #(
    parameter int BLOCK_SIDE          = 16,
    parameter int MAX_BLOCKS_PER_SIDE = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // luma, chroma_blue, chroma_red, luma_offset [47:24]
    output logic             m_tlast,   // last_pixel
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW        = $clog2(BLOCK_SIDE);
    localparam int BCW       = (MAX_BLOCKS_PER_SIDE > 1) ? $clog2(MAX_BLOCKS_PER_SIDE) : 1;
    localparam int MCU_BYTES = 3 * BLOCK_SIDE * BLOCK_SIDE;
    localparam int LW        = ryw_pkg::LIMIT_W;
    localparam int OW        = ryw_pkg::OFFSET_W;
    localparam logic [LW-1:0] MAX_LIM = LW'(MAX_BLOCKS_PER_SIDE);

    // config
    logic [7:0] width_reg, height_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
        end
        else if (cfg_wr)
        begin
            case (ryw_pkg::reg_index_t'(paddr[2]))
                ryw_pkg::REG_WIDTH_IN_MCUS:  width_reg  <= pwdata[7:0];
                ryw_pkg::REG_HEIGHT_IN_MCUS: height_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ryw_pkg::reg_index_t'(paddr[2]))
            ryw_pkg::REG_WIDTH_IN_MCUS:  prdata = {24'd0, width_reg};
            ryw_pkg::REG_HEIGHT_IN_MCUS: prdata = {24'd0, height_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // pipeline control
    logic s1_valid_reg, s2_valid_reg;
    logic advance, s_acc;

    assign advance  = !s2_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign s_acc    = s_tvalid && s_tready;

    // raster counters
    logic [CW-1:0]  col_reg, col_next, row_reg, row_next;
    logic [BCW-1:0] bcol_reg, bcol_next, brow_reg, brow_next;
    logic [OW-1:0]  band_reg, band_next;
    logic [LW-1:0]  wb, hb;
    logic           col_end, bcol_end, row_end, brow_end, last_now;
    logic [OW-1:0]  offset_now;

    assign wb = ryw_pkg::limit_blocks(width_reg, MAX_LIM);
    assign hb = ryw_pkg::limit_blocks(height_reg, MAX_LIM);

    assign col_end  = col_reg == CW'(BLOCK_SIDE - 1);
    assign row_end  = row_reg == CW'(BLOCK_SIDE - 1);
    assign bcol_end = (LW'(bcol_reg) + LW'(1)) >= wb;
    assign brow_end = (LW'(brow_reg) + LW'(1)) >= hb;
    assign last_now = col_end && bcol_end && row_end && brow_end;

    assign offset_now = band_reg + OW'(bcol_reg * MCU_BYTES)
                      + OW'(row_reg * BLOCK_SIDE) + OW'(col_reg);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        bcol_next = bcol_reg;
        brow_next = brow_reg;
        band_next = band_reg;
        if (!col_end)
            col_next = col_reg + CW'(1);
        else
        begin
            col_next = '0;
            if (!bcol_end)
                bcol_next = bcol_reg + BCW'(1);
            else
            begin
                bcol_next = '0;
                if (!row_end)
                    row_next = row_reg + CW'(1);
                else
                begin
                    row_next = '0;
                    if (!brow_end)
                    begin
                        brow_next = brow_reg + BCW'(1);
                        band_next = band_reg + OW'(wb * MCU_BYTES);
                    end
                    else
                    begin
                        brow_next = '0;
                        band_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            bcol_reg <= '0;
            brow_reg <= '0;
            band_reg <= '0;
        end
        else if (s_acc)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            bcol_reg <= bcol_next;
            brow_reg <= brow_next;
            band_reg <= band_next;
        end
    end

    // stage 1: input register
    logic [23:0]   rgb_reg;
    logic [OW-1:0] s1_offset_reg;
    logic          s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            rgb_reg       <= s_tdata;
            s1_offset_reg <= offset_now;
            s1_last_reg   <= last_now;
        end
    end

    // color conversion
    ryw_pkg::acc_t ya, cba, cra;
    int r, g, b;

    assign r = int'(rgb_reg[7:0]);
    assign g = int'(rgb_reg[15:8]);
    assign b = int'(rgb_reg[23:16]);

    assign ya  = ryw_pkg::ACC_W'(ryw_pkg::Y_R * r + ryw_pkg::Y_G * g + ryw_pkg::Y_B * b);
    assign cba = ryw_pkg::ACC_W'(ryw_pkg::CB_R * r + ryw_pkg::CB_G * g
                                 + ryw_pkg::CB_B * b + ryw_pkg::C_OFS);
    assign cra = ryw_pkg::ACC_W'(ryw_pkg::CR_R * r + ryw_pkg::CR_G * g
                                 + ryw_pkg::CR_B * b + ryw_pkg::C_OFS);

    // stage 2: result register
    logic [47:0] s2_data_reg;
    logic        s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_data_reg <= {s1_offset_reg, ryw_pkg::q16_to_byte(cra),
                            ryw_pkg::q16_to_byte(cba), ryw_pkg::q16_to_byte(ya)};
            s2_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = s2_data_reg;
    assign m_tlast  = s2_last_reg;

    // checks
    `RYW_ASSERT_NEXT(a_wrap_after_last, s_acc && last_now,
        col_reg == '0 && row_reg == '0 && bcol_reg == '0 && brow_reg == '0 && band_reg == '0,
        "counters not cleared after last pixel")
    `RYW_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !advance,
        s1_valid_reg && $stable(rgb_reg) && $stable(s1_offset_reg),
        "stage 1 item lost during stall")
    `RYW_ASSERT_NOW(a_col_range, 1'b1,
        LW'(col_reg) < LW'(BLOCK_SIDE) && LW'(row_reg) < LW'(BLOCK_SIDE),
        "pixel counter out of block")
    `RYW_ASSERT_NEXT(a_s2_load, advance && s1_valid_reg, s2_valid_reg,
        "stage 1 item dropped on advance")

endmodule

`default_nettype wire
